[hw/rtl/sqe_pkg.sv]
// Shared constants, types and ring helper for the stack and queue engine.
`default_nettype none

package sqe_pkg;

  // Store geometry.
  localparam int DEPTH = 64;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  // Payload widths.
  localparam int VALUE_W  = 32;
  localparam int MODE_W   = 3;
  localparam int STATUS_W = 3;

  // Operation codes carried on in_tuser.
  localparam logic [MODE_W-1:0] MODE_PUSH = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DUMP = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PEEK = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SWAP = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PEEK_EMPTY = 3'd1;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SWAP_SHORT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_PUSH_FULL  = 3'd4;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EMIT,
    S_PEEK,
    S_DUMP,
    S_SW_A,
    S_SW_B,
    S_SW_C
  } state_t;

  // Slot at a given offset below the top, wrapping around the ring.
  // The offset never exceeds DEPTH, so one conditional subtract suffices.
  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] ptr,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(ptr) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/sqe_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module sqe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/stack_queue_engine.sv]
// Top level of the stack and queue engine: sequencer, pointers and output register.
// Push, pop, peek and error items: result registered in the output register once it is free;
// the next item is taken only after that. Swap: two reads and two writes on the RAM, then a status result.
// Dump of n entries: one RAM read per entry, one result per entry; an empty store gives one status result.
// Items are taken only in the idle state, so the sequencer, not the entry RAM ports, sets the throughput.
// Synchronous active-low reset empties the store and selects stack order; no clearing pass.
`default_nettype none

module stack_queue_engine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,  // [31:0] value
  input  wire logic [2:0]  in_tuser,  // [2:0] mode
  // Result channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata, // [31:0] data
  output logic [3:0]       out_tuser, // [0] data_valid, [3:1] status
  output logic             out_tlast,
  // Configuration channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data
);

  // Control state.
  sqe_pkg::state_t state_r, state_nxt;
  logic [sqe_pkg::PTR_W-1:0]    top_r, top_nxt;
  logic [sqe_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [sqe_pkg::PTR_W-1:0]    idx_r, idx_nxt;
  logic                         queue_order_r;
  logic [sqe_pkg::VALUE_W-1:0]  tmp_r, tmp_nxt;
  logic [sqe_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;

  // Output register.
  logic                         out_valid_r;
  logic [31:0]                  out_data_r, out_data_nxt;
  logic [3:0]                   out_user_r, out_user_nxt;
  logic                         out_last_r, out_last_nxt;
  logic                         out_load;
  logic                         out_free;

  // RAM ports.
  logic                         mem_we, mem_re;
  logic [sqe_pkg::PTR_W-1:0]    mem_waddr, mem_raddr;
  logic [sqe_pkg::VALUE_W-1:0]  mem_wdata, mem_rdata;

  // Helpers.
  logic                         in_fire;
  logic [sqe_pkg::PTR_W-1:0]    top_dec, top_inc;
  logic [sqe_pkg::CNT_W-1:0]    idx_inc;
  logic                         dump_last;

  sqe_ram #(
    .WIDTH(sqe_pkg::VALUE_W),
    .DEPTH(sqe_pkg::DEPTH)
  ) u_entries (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign cfg_ready  = 1'b1;
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign top_dec    = (top_r == '0) ? sqe_pkg::PTR_W'(sqe_pkg::DEPTH - 1)
                                    : top_r - sqe_pkg::PTR_W'(1);
  assign top_inc    = sqe_pkg::ring_add(top_r, sqe_pkg::CNT_W'(1));
  assign idx_inc    = sqe_pkg::CNT_W'(idx_r) + sqe_pkg::CNT_W'(1);
  assign dump_last  = (idx_inc == count_r);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  // Sequencer state and store pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= sqe_pkg::S_IDLE;
      top_r         <= '0;
      count_r       <= '0;
      idx_r         <= '0;
      queue_order_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      top_r   <= top_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      if (cfg_valid && cfg_ready) begin
        queue_order_r <= cfg_data;
      end
    end
  end

  // Working payload registers.
  always_ff @(posedge clk) begin
    tmp_r        <= tmp_nxt;
    res_status_r <= res_status_nxt;
  end

  // Output register: valid is control, the rest is payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  // Next state, RAM accesses and result formation.
  always_comb begin
    state_nxt      = state_r;
    top_nxt        = top_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    tmp_nxt        = tmp_r;
    res_status_nxt = res_status_r;
    in_tready      = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = top_r;
    mem_wdata      = in_tdata;
    mem_re         = 1'b0;
    mem_raddr      = top_r;
    out_load       = 1'b0;
    out_data_nxt   = '0;
    out_user_nxt   = {sqe_pkg::ST_OK, 1'b0};
    out_last_nxt   = 1'b1;

    unique case (state_r)
      sqe_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_fire) begin
          state_nxt      = sqe_pkg::S_EMIT;
          res_status_nxt = sqe_pkg::ST_OK;
          unique case (in_tuser)
            sqe_pkg::MODE_PUSH: begin
              if (count_r == sqe_pkg::CNT_W'(sqe_pkg::DEPTH)) begin
                res_status_nxt = sqe_pkg::ST_PUSH_FULL;
              end else begin
                mem_we    = 1'b1;
                count_nxt = count_r + sqe_pkg::CNT_W'(1);
                if (queue_order_r) begin
                  mem_waddr = sqe_pkg::ring_add(top_r, count_r);
                end else begin
                  mem_waddr = top_dec;
                  top_nxt   = top_dec;
                end
              end
            end
            sqe_pkg::MODE_DUMP: begin
              if (count_r != '0) begin
                mem_re    = 1'b1;
                idx_nxt   = '0;
                state_nxt = sqe_pkg::S_DUMP;
              end
            end
            sqe_pkg::MODE_PEEK: begin
              if (count_r == '0) begin
                res_status_nxt = sqe_pkg::ST_PEEK_EMPTY;
              end else begin
                mem_re    = 1'b1;
                state_nxt = sqe_pkg::S_PEEK;
              end
            end
            sqe_pkg::MODE_POP: begin
              if (count_r == '0) begin
                res_status_nxt = sqe_pkg::ST_POP_EMPTY;
              end else begin
                top_nxt   = top_inc;
                count_nxt = count_r - sqe_pkg::CNT_W'(1);
              end
            end
            sqe_pkg::MODE_SWAP: begin
              if (count_r < sqe_pkg::CNT_W'(2)) begin
                res_status_nxt = sqe_pkg::ST_SWAP_SHORT;
              end else begin
                mem_re    = 1'b1;
                state_nxt = sqe_pkg::S_SW_A;
              end
            end
            default: begin
              res_status_nxt = sqe_pkg::ST_OK;
            end
          endcase
        end
      end

      // Swap: hold the old top, read the entry below it.
      sqe_pkg::S_SW_A: begin
        tmp_nxt   = mem_rdata;
        mem_re    = 1'b1;
        mem_raddr = top_inc;
        state_nxt = sqe_pkg::S_SW_B;
      end

      // Swap: the entry below moves to the top.
      sqe_pkg::S_SW_B: begin
        mem_we    = 1'b1;
        mem_waddr = top_r;
        mem_wdata = mem_rdata;
        state_nxt = sqe_pkg::S_SW_C;
      end

      // Swap: the old top moves one slot down.
      sqe_pkg::S_SW_C: begin
        mem_we         = 1'b1;
        mem_waddr      = top_inc;
        mem_wdata      = tmp_r;
        res_status_nxt = sqe_pkg::ST_OK;
        state_nxt      = sqe_pkg::S_EMIT;
      end

      // Single status-only result.
      sqe_pkg::S_EMIT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_user_nxt = {res_status_r, 1'b0};
          state_nxt    = sqe_pkg::S_IDLE;
        end
      end

      // Peek result; RAM read data holds while the output is stalled.
      sqe_pkg::S_PEEK: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_data_nxt = mem_rdata;
          out_user_nxt = {sqe_pkg::ST_OK, 1'b1};
          state_nxt    = sqe_pkg::S_IDLE;
        end
      end

      // Dump: emit the entry just read and fetch the next one.
      sqe_pkg::S_DUMP: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_data_nxt = mem_rdata;
          out_user_nxt = {sqe_pkg::ST_OK, 1'b1};
          out_last_nxt = dump_last;
          if (dump_last) begin
            state_nxt = sqe_pkg::S_IDLE;
          end else begin
            idx_nxt   = idx_inc[sqe_pkg::PTR_W-1:0];
            mem_re    = 1'b1;
            mem_raddr = sqe_pkg::ring_add(top_r, idx_inc);
          end
        end
      end

      default: begin
        state_nxt = sqe_pkg::S_IDLE;
      end
    endcase
  end

  // The fill level never passes the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= sqe_pkg::CNT_W'(sqe_pkg::DEPTH))
    else $error("entry count exceeds depth");

  // Only dump results may leave last low, and they always carry data.
  a_notlast_dump: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> out_user_r[0])
    else $error("non-final result without entry data");

  // A successful pop drops the fill level by one.
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tuser == sqe_pkg::MODE_POP && count_r != '0
    |=> count_r == $past(count_r) - sqe_pkg::CNT_W'(1))
    else $error("pop did not decrement the entry count");

  // The RAM is written only on push acceptance or during a swap.
  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> state_r == sqe_pkg::S_IDLE || state_r == sqe_pkg::S_SW_B
               || state_r == sqe_pkg::S_SW_C)
    else $error("entry write outside push or swap");

  // Items are never taken while a dump or the first swap step is in progress.
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sqe_pkg::S_DUMP || state_r == sqe_pkg::S_SW_A |-> !in_fire)
    else $error("item accepted while busy");

endmodule

`default_nettype wire

[verif/tb_stack_queue_engine.sv]
// Self-checking testbench for the stack and queue engine: directed and random items.
`default_nettype none

module tb_stack_queue_engine;

  // Codes with no operation behind them; the engine answers them with an empty result.
  localparam logic [sqe_pkg::MODE_W-1:0] MODE_UNUSED_FIRST = 3'd5;
  localparam logic [sqe_pkg::MODE_W-1:0] MODE_UNUSED_LAST  = 3'd7;

  localparam logic [sqe_pkg::VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [sqe_pkg::VALUE_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 32;
  localparam int PHASE_ITEMS   = 16;
  localparam int HOLD_CYCLES   = 200;

  // One expected result item.
  typedef struct {
    logic [sqe_pkg::VALUE_W-1:0]  data;
    logic                         data_valid;
    logic [sqe_pkg::STATUS_W-1:0] status;
    logic                         last;
  } result_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [31:0]         in_tdata   = '0;  // [31:0] value
  logic [2:0]          in_tuser   = '0;  // [2:0] mode
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [31:0]         out_tdata;        // [31:0] data
  logic [3:0]          out_tuser;        // [0] data_valid, [3:1] status
  logic                out_tlast;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic                cfg_data   = 1'b0;

  // Results the engine still owes, oldest first.
  result_t pending_results[$];
  int      fail_count = 0;

  // Shadow copy of the store and its configuration.
  logic [sqe_pkg::VALUE_W-1:0] shadow_mem [sqe_pkg::DEPTH];
  int                 shadow_top   = 0;
  int                 shadow_count = 0;
  logic               shadow_queue_order = 1'b0;

  // Idling controls shared by the sender, the receiver and the tests.
  bit tx_idle_on    = 1'b1;
  bit rx_idle_on    = 1'b1;
  int rx_hold_cycles = 0;

  stack_queue_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Free-running clock, period 20.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap(bit enable);
    int r;
    r = $urandom_range(0, 9);
    if (!enable || r < 5) return 0;
    if (r < 8) return $urandom_range(1, 3);
    if (r < 9) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic void owe_result(logic [sqe_pkg::VALUE_W-1:0] data, logic data_valid,
                                     logic [sqe_pkg::STATUS_W-1:0] status, logic last);
    result_t r;
    r.data       = data;
    r.data_valid = data_valid;
    r.status     = status;
    r.last       = last;
    pending_results.push_back(r);
  endfunction

  // Ring position of the entry a given distance below the top.
  function automatic int ring_slot(int offset);
    return (shadow_top + offset) % sqe_pkg::DEPTH;
  endfunction

  // Apply one operation to the shadow store and queue the results it causes.
  function automatic void apply_operation(logic [sqe_pkg::MODE_W-1:0] mode,
                                          logic [sqe_pkg::VALUE_W-1:0] value);
    logic [sqe_pkg::VALUE_W-1:0] held;
    case (mode)
      sqe_pkg::MODE_PUSH: begin
        if (shadow_count >= sqe_pkg::DEPTH) begin
          owe_result('0, 1'b0, sqe_pkg::ST_PUSH_FULL, 1'b1);
        end else begin
          if (shadow_queue_order) begin
            shadow_mem[ring_slot(shadow_count)] = value;
          end else begin
            shadow_top = (shadow_top + sqe_pkg::DEPTH - 1) % sqe_pkg::DEPTH;
            shadow_mem[shadow_top] = value;
          end
          shadow_count++;
          owe_result('0, 1'b0, sqe_pkg::ST_OK, 1'b1);
        end
      end
      sqe_pkg::MODE_DUMP: begin
        if (shadow_count == 0) begin
          owe_result('0, 1'b0, sqe_pkg::ST_OK, 1'b1);
        end else begin
          for (int i = 0; i < shadow_count; i++) begin
            owe_result(shadow_mem[ring_slot(i)], 1'b1, sqe_pkg::ST_OK,
                       i == shadow_count - 1);
          end
        end
      end
      sqe_pkg::MODE_PEEK: begin
        if (shadow_count == 0) begin
          owe_result('0, 1'b0, sqe_pkg::ST_PEEK_EMPTY, 1'b1);
        end else begin
          owe_result(shadow_mem[ring_slot(0)], 1'b1, sqe_pkg::ST_OK, 1'b1);
        end
      end
      sqe_pkg::MODE_POP: begin
        if (shadow_count == 0) begin
          owe_result('0, 1'b0, sqe_pkg::ST_POP_EMPTY, 1'b1);
        end else begin
          shadow_top = ring_slot(1);
          shadow_count--;
          owe_result('0, 1'b0, sqe_pkg::ST_OK, 1'b1);
        end
      end
      sqe_pkg::MODE_SWAP: begin
        if (shadow_count < 2) begin
          owe_result('0, 1'b0, sqe_pkg::ST_SWAP_SHORT, 1'b1);
        end else begin
          held = shadow_mem[ring_slot(0)];
          shadow_mem[ring_slot(0)] = shadow_mem[ring_slot(1)];
          shadow_mem[ring_slot(1)] = held;
          owe_result('0, 1'b0, sqe_pkg::ST_OK, 1'b1);
        end
      end
      default: begin
        owe_result('0, 1'b0, sqe_pkg::ST_OK, 1'b1);
      end
    endcase
  endfunction

  // Offer one item after a random gap and predict it once it is accepted.
  task automatic send_item(logic [sqe_pkg::MODE_W-1:0] mode,
                           logic [sqe_pkg::VALUE_W-1:0] value);
    int gap;
    gap = pick_gap(tx_idle_on);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    apply_operation(mode, value);
  endtask

  // Stop offering items and wait until every owed result has come back.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the order register while the engine is idle.
  task automatic write_order(logic queue_order);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= queue_order;
    do @(posedge clk); while (!cfg_ready);
    shadow_queue_order = queue_order;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Every operation but push on an empty store, the unused codes included.
  task automatic test_empty_store();
    send_item(sqe_pkg::MODE_DUMP, '0);
    send_item(sqe_pkg::MODE_PEEK, '0);
    send_item(sqe_pkg::MODE_POP, VAL_MAX);
    send_item(sqe_pkg::MODE_SWAP, VAL_MIN);
    for (int m = MODE_UNUSED_FIRST; m <= MODE_UNUSED_LAST; m++) begin
      send_item(sqe_pkg::MODE_W'(m), $urandom);
    end
  endtask

  // Stack order with the value extremes, a swap and a swap on one entry.
  task automatic test_stack_order();
    write_order(1'b0);
    send_item(sqe_pkg::MODE_PUSH, VAL_MIN);
    send_item(sqe_pkg::MODE_PUSH, VAL_MAX);
    send_item(sqe_pkg::MODE_PUSH, '0);
    send_item(sqe_pkg::MODE_PUSH, '1);
    send_item(sqe_pkg::MODE_SWAP, '0);
    send_item(sqe_pkg::MODE_PEEK, '0);
    send_item(sqe_pkg::MODE_DUMP, '0);
    repeat (3) send_item(sqe_pkg::MODE_POP, '0);
    send_item(sqe_pkg::MODE_SWAP, '0);
    send_item(sqe_pkg::MODE_POP, '0);
  endtask

  // Queue order: pushed values land below the existing ones.
  task automatic test_queue_order();
    write_order(1'b1);
    send_item(sqe_pkg::MODE_PUSH, 32'h5555_5555);
    send_item(sqe_pkg::MODE_PUSH, 32'hAAAA_AAAA);
    send_item(sqe_pkg::MODE_PUSH, 32'h0000_0001);
    send_item(sqe_pkg::MODE_SWAP, '0);
    send_item(sqe_pkg::MODE_DUMP, '0);
    send_item(sqe_pkg::MODE_POP, '0);
    send_item(sqe_pkg::MODE_PEEK, '0);
  endtask

  // Fill the store from both ends, push into a full store and dump all of it.
  task automatic test_full_store();
    write_order(1'b0);
    while (shadow_count < sqe_pkg::DEPTH / 2) send_item(sqe_pkg::MODE_PUSH, $urandom);
    write_order(1'b1);
    while (shadow_count < sqe_pkg::DEPTH) send_item(sqe_pkg::MODE_PUSH, $urandom);
    send_item(sqe_pkg::MODE_PUSH, $urandom);
    write_order(1'b0);
    send_item(sqe_pkg::MODE_PUSH, $urandom);
    send_item(sqe_pkg::MODE_DUMP, '0);
    repeat (40) send_item(sqe_pkg::MODE_POP, '0);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering items.
  task automatic test_backpressure();
    wait_idle();
    tx_idle_on = 1'b0;
    rx_hold_cycles = HOLD_CYCLES;
    for (int i = 0; i < 16; i++) begin
      send_item((i % 2 == 0) ? sqe_pkg::MODE_PUSH : sqe_pkg::MODE_PEEK, $urandom);
    end
    tx_idle_on = 1'b1;
  endtask

  // Random phases, each with its own order and idling; growth and shrink phases alternate.
  task automatic test_random();
    int counted;
    int r;
    bit grow;
    logic [sqe_pkg::MODE_W-1:0] mode;
    logic [sqe_pkg::VALUE_W-1:0] value;
    counted = 0;
    grow = 1'b1;
    while (counted < RANDOM_ITEMS) begin
      write_order(1'($urandom_range(0, 1)));
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < PHASE_ITEMS && counted < RANDOM_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < (grow ? 55 : 20)) begin
          mode = sqe_pkg::MODE_PUSH;
        end else if (r < (grow ? 65 : 60)) begin
          mode = sqe_pkg::MODE_POP;
        end else if (r < 75) begin
          mode = sqe_pkg::MODE_PEEK;
        end else if (r < 88) begin
          mode = sqe_pkg::MODE_SWAP;
        end else if (r < 95) begin
          mode = sqe_pkg::MODE_DUMP;
        end else begin
          mode = sqe_pkg::MODE_W'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
        end
        case ($urandom_range(0, 7))
          0:       value = VAL_MIN;
          1:       value = VAL_MAX;
          2:       value = '1;
          default: value = $urandom;
        endcase
        send_item(mode, value);
        if (mode <= sqe_pkg::MODE_SWAP) counted++;
      end
      grow = !grow;
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Result ready: a hold-off request first, otherwise random stalls.
  initial begin : rx_ready_gen
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        out_tready <= 1'b0;
        rx_hold_cycles--;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        stall_left = pick_gap(rx_idle_on);
      end
    end
  end

  // Compare every accepted result item with the oldest owed result.
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result item with nothing owed: data %h user %h last %b",
               out_tdata, out_tuser, out_tlast);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata !== want.data) begin
          $error("data: expected %h, actual %h", want.data, out_tdata);
          fail_count++;
        end
        if (out_tuser[0] !== want.data_valid) begin
          $error("data_valid: expected %b, actual %b", want.data_valid, out_tuser[0]);
          fail_count++;
        end
        if (out_tuser[3:1] !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_tuser[3:1]);
          fail_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %b, actual %b", want.last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // Test sequence.
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_empty_store();
    test_stack_order();
    test_queue_order();
    test_full_store();
    test_backpressure();
    test_random();
    wait_idle();
    if (fail_count == 0) begin
      $display("tb_stack_queue_engine OK");
    end else begin
      $display("tb_stack_queue_engine NOT OK");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #50_000_000;
    $display("tb_stack_queue_engine NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
